// ===== rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
package bba_pkg;

  localparam int unsigned LogEntries = 9;
  localparam int unsigned NumEntries = 1 << LogEntries;
  localparam int unsigned MinShift   = 5;
  localparam int unsigned HeapBytes  = NumEntries << MinShift;
  localparam int unsigned IdxW       = LogEntries;
  localparam int unsigned EntryW     = 5;
  localparam int unsigned LvlW       = 4;

  localparam logic [31:0] HeapBaseReset = 32'h2000_1000;

  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree  = 1'b1;

  typedef struct packed {
    logic        ok;
    logic [31:0] addr;
  } res_t;

endpackage

// ===== rtl/bba_ram.sv =====
`timescale 1ns / 1ps
module bba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bba_engine.sv =====
`timescale 1ns / 1ps
module bba_engine import bba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] heap_base_i,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic        action_i,
  input  logic [15:0] req_size_i,
  input  logic [31:0] free_addr_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output res_t        res_o
);

  localparam logic [3:0] StClr    = 4'd0;
  localparam logic [3:0] StIdle   = 4'd1;
  localparam logic [3:0] StScan   = 4'd2;
  localparam logic [3:0] StUnwRd  = 4'd3;
  localparam logic [3:0] StUnwChk = 4'd4;
  localparam logic [3:0] StFrChk  = 4'd5;
  localparam logic [3:0] StMgRd   = 4'd6;
  localparam logic [3:0] StMgChk  = 4'd7;
  localparam logic [3:0] StMgWr   = 4'd8;
  localparam logic [3:0] StDone   = 4'd9;

  localparam logic [LvlW-1:0] TopLvl = LvlW'(LogEntries);

  logic [3:0]          state_q, state_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [IdxW:0]       issue_q, issue_d;
  logic                pend_q, pend_d;
  logic [IdxW-1:0]     pend_addr_q, pend_addr_d;
  logic [LvlW-1:0]     tlvl_q, tlvl_d;
  logic [LvlW-1:0]     lvl_q, lvl_d;
  res_t                res_q, res_d;

  logic                we;
  logic [IdxW-1:0]     waddr, raddr;
  logic [EntryW-1:0]   wdata, rdata;

  logic [16:0]         nblk;
  logic [IdxW:0]       nm1;
  logic [LvlW-1:0]     tcalc;
  logic [31:0]         off;
  logic [IdxW-1:0]     lvl_bit, lvl_mask, buddy, mid;
  logic                hit;

  bba_ram #(.Width(EntryW), .Depth(NumEntries)) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // smallest level whose block holds the request
  always_comb begin
    nblk  = (17'(req_size_i) + 17'((1 << MinShift) - 1)) >> MinShift;
    nm1   = (IdxW + 1)'(nblk - 17'd1);
    tcalc = '0;
    for (int k = 0; k <= IdxW; k++) begin
      if (nm1[k]) tcalc = LvlW'(k + 1);
    end
  end

  assign off      = free_addr_i - heap_base_i;
  assign lvl_bit  = IdxW'(1) << lvl_q;
  assign lvl_mask = {IdxW{1'b1}} << lvl_q;
  assign buddy    = idx_q ^ lvl_bit;
  // lvl_q is at least one in the unwind states
  assign mid      = (idx_q & lvl_mask) | (IdxW'(1) << (lvl_q - LvlW'(1)));
  assign hit      = !rdata[0] && (rdata[EntryW-1:1] > tlvl_q);

  assign req_ready_o = (state_q == StIdle);
  assign res_valid_o = (state_q == StDone);
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    issue_d     = issue_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    tlvl_d      = tlvl_q;
    lvl_d       = lvl_q;
    res_d       = res_q;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = '0;
    raddr       = idx_q;
    unique case (state_q)
      StClr: begin
        we    = 1'b1;
        waddr = idx_q;
        wdata = (idx_q == '0) ? {TopLvl + LvlW'(1), 1'b0} : '0;
        idx_d = idx_q + IdxW'(1);
        if (idx_q == {IdxW{1'b1}}) state_d = StIdle;
      end
      StIdle: begin
        if (req_valid_i) begin
          res_d = '{ok: 1'b0, addr: 32'd0};
          if (action_i == ActAlloc) begin
            if (req_size_i == 16'd0 || 32'(req_size_i) > 32'(HeapBytes)) begin
              state_d = StDone;
            end else begin
              tlvl_d  = tcalc;
              issue_d = '0;
              state_d = StScan;
            end
          end else begin
            if (off >= 32'(HeapBytes) || off[MinShift-1:0] != '0) begin
              state_d = StDone;
            end else begin
              idx_d   = off[MinShift +: IdxW];
              raddr   = off[MinShift +: IdxW];
              res_d.addr = free_addr_i;
              state_d = StFrChk;
            end
          end
        end
      end
      StScan: begin
        // one candidate read per cycle, its data checked in the next cycle
        if (pend_q && hit) begin
          we      = 1'b1;
          waddr   = pend_addr_q;
          wdata   = {tlvl_q + LvlW'(1), 1'b1};
          idx_d   = pend_addr_q;
          lvl_d   = tlvl_q + LvlW'(1);
          state_d = StUnwRd;
        end else if (!issue_q[IdxW]) begin
          raddr       = issue_q[IdxW-1:0];
          pend_d      = 1'b1;
          pend_addr_d = issue_q[IdxW-1:0];
          issue_d     = issue_q + ((IdxW + 1)'(1) << tlvl_q);
        end else if (!pend_q) begin
          state_d = StDone;
        end
      end
      StUnwRd: begin
        if (lvl_q > TopLvl) begin
          res_d.ok   = 1'b1;
          res_d.addr = heap_base_i + (32'(idx_q) << MinShift);
          state_d    = StDone;
        end else if (!idx_q[lvl_q - LvlW'(1)]) begin
          raddr   = mid;
          state_d = StUnwChk;
        end else begin
          lvl_d = lvl_q + LvlW'(1);
        end
      end
      StUnwChk: begin
        if (rdata == '0) begin
          we    = 1'b1;
          waddr = mid;
          wdata = {lvl_q, 1'b0};
        end
        lvl_d   = lvl_q + LvlW'(1);
        state_d = StUnwRd;
      end
      StFrChk: begin
        if (!rdata[0] || rdata[EntryW-1:1] == '0) begin
          res_d.addr = '0;
          state_d    = StDone;
        end else begin
          we      = 1'b1;
          waddr   = idx_q;
          wdata   = {rdata[EntryW-1:1], 1'b0};
          lvl_d   = rdata[EntryW-1:1] - LvlW'(1);
          res_d.ok = 1'b1;
          state_d = StMgRd;
        end
      end
      StMgRd: begin
        if (lvl_q >= TopLvl) begin
          state_d = StDone;
        end else begin
          raddr   = buddy;
          state_d = StMgChk;
        end
      end
      StMgChk: begin
        if (rdata == {lvl_q + LvlW'(1), 1'b0}) begin
          we      = 1'b1;
          waddr   = idx_q | lvl_bit;
          wdata   = '0;
          state_d = StMgWr;
        end else begin
          state_d = StDone;
        end
      end
      StMgWr: begin
        we      = 1'b1;
        waddr   = idx_q & ~lvl_bit;
        wdata   = {lvl_q + LvlW'(2), 1'b0};
        idx_d   = idx_q & ~lvl_bit;
        lvl_d   = lvl_q + LvlW'(1);
        state_d = StMgRd;
      end
      StDone: begin
        if (res_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr;
      idx_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    issue_q     <= issue_d;
    pend_addr_q <= pend_addr_d;
    tlvl_q      <= tlvl_d;
    lvl_q       <= lvl_d;
    res_q       <= res_d;
  end

endmodule

// ===== rtl/buddy_block_allocator_top.sv =====
`timescale 1ns / 1ps
// channel | direction | tdata                         | tuser
// s_axis  | in        | [15:0] req_size [47:16] addr  | action (0 alloc, 1 free)
// m_axis  | out       | [31:0] result_addr            | ok
// cfg     | in        | [31:0] heap_base, no handshake| -
// after reset the block table is cleared entry by entry before s_axis_tready_o rises
// alloc: a scan of table reads, then an unwind through the levels above the block
// free: three table accesses per merge level
// one request at a time; a result waits in the output register while the next is taken
module buddy_block_allocator_top import bba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // req_size, free_addr
  input  logic        s_axis_tuser_i,   // action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // result_addr
  output logic        m_axis_tuser_o,   // ok
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [31:0] heap_base_q;
  logic        out_valid_q, out_valid_d;
  res_t        out_q, out_d;
  logic        res_valid, res_ready;
  res_t        res;

  bba_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .heap_base_i(heap_base_q),
    .req_valid_i(s_axis_tvalid_i),
    .req_ready_o(s_axis_tready_o),
    .action_i   (s_axis_tuser_i),
    .req_size_i (s_axis_tdata_i[15:0]),
    .free_addr_i(s_axis_tdata_i[47:16]),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (m_axis_tready_i) out_valid_d = 1'b0;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= HeapBaseReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) heap_base_q <= cfg_wdata_i;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.addr;
  assign m_axis_tuser_o  = out_q.ok;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("engine took a second request while busy");

  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && res_valid))
    else $error("engine idle with a result pending");

  a_fail_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == 32'd0)
    else $error("failed transfer carries a nonzero address");

endmodule
